// ===== rtl/core/mbrx_pkg.sv =====
// shared types and constants of the modbus tcp response receiver
`timescale 1ns / 1ps
package mbrx_pkg;

  // frame buffer geometry
  localparam int BUFFER_BYTES = 260;
  localparam int HEADER_BYTES = 7;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

  // fixed field widths
  localparam int FLEN_W   = 9;
  localparam int IDX_W    = 9;
  localparam int TMO_W    = 16;
  localparam int TICK_W   = 17;
  localparam int TID_W    = 16;
  localparam int UNIT_W   = 8;
  localparam int FUNC_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int HDR_KEEP = 8;

  localparam logic [TMO_W-1:0]  TMO_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX  = 17'h1FFFF;
  localparam int                MBAP_PRE  = 6;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RECV = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_BUSY      = 4'd1,
    ST_STORED    = 4'd2,
    ST_IGNORED   = 4'd3,
    ST_VALID     = 4'd4,
    ST_BAD_TRANS = 4'd5,
    ST_BAD_PROTO = 4'd6,
    ST_BAD_UNIT  = 4'd7,
    ST_BAD_FUNC  = 4'd8,
    ST_OVERFLOW  = 4'd9,
    ST_TIMEOUT   = 4'd10,
    ST_READ      = 4'd11
  } status_e;

  // one result item
  typedef struct packed {
    status_e            status;
    phase_e             phase_now;
    logic [TID_W-1:0]   transaction_number;
    logic [BYTE_W-1:0]  data_byte;
    logic [FLEN_W-1:0]  frame_length;
    logic               exception_flag;
  } result_t;

  // result in flight while the buffer read completes
  typedef struct packed {
    logic    valid;
    logic    take_ram;
    result_t res;
  } stage_t;

  // access to the frame buffer
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/core/modbus_tcp_response_receiver.sv =====
// top level of the modbus tcp client response receiver
`timescale 1ns / 1ps
// Takes one item per clock cycle on the slave stream while s_axis_tready is
// high and returns exactly one result per item on the master stream, after
// the registered result stage and the result queue. Read data of the frame
// buffer ram is registered, so reads of stored bytes finish in the cycle
// after the item is taken; the small result queue decouples the two sides so
// that a new item is taken while an earlier result still waits. The buffer is
// not cleared after reset; only bytes below the current frame length are ever
// read back, and a read at or above it returns zero. The timeout register may
// be written at any time the block is idle and takes effect on the next tick.
module modbus_tcp_response_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: response_timeout_ticks
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // unit_id[7:0], function_code[14:8], rx_byte[22:15], read_index[31:23]
  input  logic [31:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // phase_now[1:0], transaction_number[17:2], data_byte[25:18],
  // frame_length[34:26], exception_flag[35], zero fill[39:36]
  output logic [39:0] m_axis_tdata,
  // status[3:0]
  output logic [3:0]  m_axis_tuser
);

  logic                         s_acc;
  logic                         cfg_we;
  mbrx_pkg::ram_req_t           ram_req;
  mbrx_pkg::stage_t             stage;
  logic [mbrx_pkg::BYTE_W-1:0]  ram_rdata;
  mbrx_pkg::result_t            push_res;
  mbrx_pkg::result_t            out_res;
  logic [1:0]                   q_level;

  // accept while queue plus stage leave room, or the head leaves this cycle
  assign s_axis_tready = ((32'(q_level) + 32'(stage.valid)) <= 32'd1) || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;

  mbrx_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .acc_i           (s_acc),
    .op_i            (mbrx_pkg::op_e'(s_axis_tuser)),
    .unit_id_i       (s_axis_tdata[7:0]),
    .function_code_i (s_axis_tdata[14:8]),
    .rx_byte_i       (s_axis_tdata[22:15]),
    .read_index_i    (s_axis_tdata[31:23]),
    .ram_req_o       (ram_req),
    .stage_o         (stage)
  );

  mbrx_ram #(
    .WIDTH (mbrx_pkg::BYTE_W),
    .DEPTH (mbrx_pkg::BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.addr),
    .rdata_o (ram_rdata)
  );

  // merge the buffer byte into the staged result
  always_comb begin
    push_res           = stage.res;
    push_res.data_byte = stage.take_ram ? ram_rdata : '0;
  end

  mbrx_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (stage.valid),
    .push_data_i (push_res),
    .pop_ready_i (m_axis_tready),
    .pop_valid_o (m_axis_tvalid),
    .pop_data_o  (out_res),
    .level_o     (q_level)
  );

  // pack the master beat
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {4'b0000,
                         out_res.exception_flag,
                         out_res.frame_length,
                         out_res.data_byte,
                         out_res.transaction_number,
                         out_res.phase_now};

  // every accepted beat shows up in the stage in the following cycle
  a_stage_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> stage.valid)
    else $error("accepted beat did not reach the result stage");

  // buffer reads only come from read items
  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.valid && stage.take_ram |-> stage.res.status == mbrx_pkg::ST_READ)
    else $error("buffer byte taken for a non-read result");

  // one buffer access per cycle
  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("buffer written and read in the same cycle");

  // end of exchange statuses leave the block idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.valid && (stage.res.status == mbrx_pkg::ST_VALID
      || stage.res.status == mbrx_pkg::ST_OVERFLOW
      || stage.res.status == mbrx_pkg::ST_TIMEOUT)
    |-> stage.res.phase_now == mbrx_pkg::PH_IDLE)
    else $error("exchange ended but phase is not idle");

endmodule

// ===== rtl/core/mbrx_ram.sv =====
// generic single port write, single port read ram with registered read data
`timescale 1ns / 1ps
module mbrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mbrx_ctrl.sv =====
// exchange control: phase, counters, header shadow and frame checks
`timescale 1ns / 1ps
module mbrx_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mbrx_pkg::TMO_W-1:0]             cfg_data_i,
  input  logic                                   acc_i,
  input  mbrx_pkg::op_e                          op_i,
  input  logic [mbrx_pkg::UNIT_W-1:0]            unit_id_i,
  input  logic [mbrx_pkg::FUNC_W-1:0]            function_code_i,
  input  logic [mbrx_pkg::BYTE_W-1:0]            rx_byte_i,
  input  logic [mbrx_pkg::IDX_W-1:0]             read_index_i,
  output mbrx_pkg::ram_req_t                     ram_req_o,
  output mbrx_pkg::stage_t                       stage_o
);

  logic [mbrx_pkg::TMO_W-1:0]  tmo_q;
  logic [mbrx_pkg::TID_W-1:0]  tid_q, tid_d;
  logic [mbrx_pkg::UNIT_W-1:0] unit_q, unit_d;
  logic [mbrx_pkg::FUNC_W-1:0] func_q, func_d;
  mbrx_pkg::phase_e            ph_q, ph_d;
  logic [mbrx_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [mbrx_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [mbrx_pkg::BYTE_W-1:0] hdr_q [mbrx_pkg::HDR_KEEP];
  logic [mbrx_pkg::BYTE_W-1:0] hdr_d [mbrx_pkg::HDR_KEEP];
  mbrx_pkg::stage_t            st_q, st_d;
  mbrx_pkg::ram_req_t          req;

  logic [mbrx_pkg::CNT_W-1:0]  base_cnt;
  logic [mbrx_pkg::CNT_W-1:0]  next_cnt;
  logic [15:0]                 plen;
  logic                        exc;
  mbrx_pkg::status_e           chk;

  // frame checks on the header as it stands after the current byte
  always_comb begin
    plen = {hdr_d[4], hdr_d[5]};
    exc  = 1'b0;
    if (32'(next_cnt) >= 32'd8) begin
      exc = hdr_d[7][7];
    end
    if ({hdr_d[0], hdr_d[1]} != tid_q) begin
      chk = mbrx_pkg::ST_BAD_TRANS;
    end else if ((hdr_d[2] | hdr_d[3]) != 8'h00) begin
      chk = mbrx_pkg::ST_BAD_PROTO;
    end else if (hdr_d[6] != unit_q) begin
      chk = mbrx_pkg::ST_BAD_UNIT;
    end else if (32'(next_cnt) < 32'd8 || hdr_d[7][6:0] != func_q) begin
      chk = mbrx_pkg::ST_BAD_FUNC;
    end else begin
      chk = mbrx_pkg::ST_VALID;
    end
  end

  // next state per item
  always_comb begin
    tid_d    = tid_q;
    unit_d   = unit_q;
    func_d   = func_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    tick_d   = tick_q;
    hdr_d    = hdr_q;
    base_cnt = (ph_q == mbrx_pkg::PH_WAIT) ? '0 : cnt_q;
    next_cnt = base_cnt + 1'b1;
    req      = '0;
    st_d     = '0;
    st_d.res.status = mbrx_pkg::ST_IGNORED;

    // header shadow follows the incoming byte
    if (acc_i && op_i == mbrx_pkg::OP_BYTE && ph_q != mbrx_pkg::PH_IDLE
        && 32'(base_cnt) < mbrx_pkg::HDR_KEEP) begin
      hdr_d[base_cnt[2:0]] = rx_byte_i;
    end

    if (acc_i) begin
      st_d.valid = 1'b1;
      case (op_i)
        mbrx_pkg::OP_START: begin
          if (ph_q == mbrx_pkg::PH_IDLE) begin
            tid_d  = tid_q + 1'b1;
            unit_d = unit_id_i;
            func_d = function_code_i;
            tick_d = '0;
            cnt_d  = '0;
            ph_d   = mbrx_pkg::PH_WAIT;
            st_d.res.status = mbrx_pkg::ST_ACCEPTED;
          end else begin
            st_d.res.status = mbrx_pkg::ST_BUSY;
          end
        end
        mbrx_pkg::OP_BYTE: begin
          if (ph_q != mbrx_pkg::PH_IDLE) begin
            ph_d  = mbrx_pkg::PH_RECV;
            cnt_d = base_cnt;
            if (32'(base_cnt) >= mbrx_pkg::BUFFER_BYTES) begin
              ph_d = mbrx_pkg::PH_IDLE;
              st_d.res.status = mbrx_pkg::ST_OVERFLOW;
            end else begin
              req.we    = 1'b1;
              req.addr  = mbrx_pkg::ADDR_W'(base_cnt);
              req.wdata = rx_byte_i;
              cnt_d     = next_cnt;
              st_d.res.status = mbrx_pkg::ST_STORED;
              if (32'(next_cnt) >= mbrx_pkg::HEADER_BYTES
                  && 32'(plen) == 32'(next_cnt) - mbrx_pkg::MBAP_PRE) begin
                ph_d = mbrx_pkg::PH_IDLE;
                st_d.res.status         = chk;
                st_d.res.exception_flag = exc;
              end
            end
          end
        end
        mbrx_pkg::OP_TICK: begin
          if (ph_q != mbrx_pkg::PH_IDLE) begin
            if (tick_q < mbrx_pkg::TICK_MAX) begin
              tick_d = tick_q + 1'b1;
            end
            if (tick_d > {1'b0, tmo_q}) begin
              ph_d = mbrx_pkg::PH_IDLE;
              st_d.res.status = mbrx_pkg::ST_TIMEOUT;
            end
          end
        end
        mbrx_pkg::OP_READ: begin
          st_d.res.status = mbrx_pkg::ST_READ;
          if (32'(read_index_i) < 32'(cnt_q)
              && 32'(read_index_i) < mbrx_pkg::BUFFER_BYTES) begin
            req.re        = 1'b1;
            req.addr      = mbrx_pkg::ADDR_W'(read_index_i);
            st_d.take_ram = 1'b1;
          end
        end
        default: begin
          st_d.res.status = mbrx_pkg::ST_IGNORED;
        end
      endcase
    end

    st_d.res.phase_now          = ph_d;
    st_d.res.transaction_number = tid_d;
    st_d.res.frame_length       = mbrx_pkg::FLEN_W'(cnt_d);
  end

  // control state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q    <= mbrx_pkg::TMO_RESET;
      tid_q    <= '0;
      unit_q   <= '0;
      func_q   <= '0;
      ph_q     <= mbrx_pkg::PH_IDLE;
      cnt_q    <= '0;
      tick_q   <= '0;
      st_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        tmo_q <= cfg_data_i;
      end
      tid_q      <= tid_d;
      unit_q     <= unit_d;
      func_q     <= func_d;
      ph_q       <= ph_d;
      cnt_q      <= cnt_d;
      tick_q     <= tick_d;
      st_q       <= st_d;
    end
  end

  // header shadow
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign ram_req_o = req;
  assign stage_o   = st_q;

endmodule

// ===== rtl/core/mbrx_outq.sv =====
// two entry result queue in front of the master side
`timescale 1ns / 1ps
module mbrx_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbrx_pkg::result_t push_data_i,
  input  logic              pop_ready_i,
  output logic              pop_valid_o,
  output mbrx_pkg::result_t pop_data_o,
  output logic [1:0]        level_o
);

  mbrx_pkg::result_t ent_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        lvl_q, lvl_d;
  logic              pop;

  assign pop = pop_ready_i && (lvl_q != 2'd0);

  // pointer and fill level
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    lvl_d = lvl_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      lvl_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  assign pop_valid_o = (lvl_q != 2'd0);
  assign pop_data_o  = ent_q[rd_q];
  assign level_o     = lvl_q;

endmodule

// ===== sim/modbus_tcp_response_receiver_tb.sv =====
// self-checking testbench for the modbus tcp response receiver
`timescale 1ns / 1ps

module modbus_tcp_response_receiver_tb;
  import mbrx_pkg::*;

  // shapes of the response frames fed to the block
  typedef enum int {
    RK_VALID,
    RK_BAD_TID,
    RK_BAD_PROTO,
    RK_BAD_UNIT,
    RK_BAD_FUNC,
    RK_SHORT,
    RK_TIMEOUT,
    RK_OVERFLOW
  } resp_kind_e;

  localparam int RK_COUNT     = 8;
  localparam int MAX_REPORTS  = 100;
  localparam int PHASE_ITEMS  = 16;
  localparam int HOLD_CYCLES  = 300;

  // tracks the receiver state, predicts each result and checks the output
  class modbus_rx_scoreboard;
    logic [TMO_W-1:0]  timeout_ticks;
    logic [TID_W-1:0]  tid_count;
    logic [UNIT_W-1:0] unit_exp;
    logic [FUNC_W-1:0] func_exp;
    phase_e            ph;
    int unsigned       nbytes;
    int unsigned       ticks;
    logic [BYTE_W-1:0] frame [BUFFER_BYTES];
    result_t           awaited_results[$];
    int unsigned       errors;
    int unsigned       results_checked;
    int unsigned       status_seen[16];

    function new();
      timeout_ticks = TMO_RESET;
      tid_count     = '0;
      unit_exp      = '0;
      func_exp      = '0;
      ph            = PH_IDLE;
      nbytes        = 0;
      ticks         = 0;
      errors        = 0;
      results_checked = 0;
      foreach (frame[i]) frame[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // header checks of a complete frame, in priority order
    function status_e judge_frame(output logic exc);
      logic [15:0] tid_rx;
      tid_rx = {frame[0], frame[1]};
      exc = 1'b0;
      if (nbytes >= HEADER_BYTES + 1) exc = frame[7][7];
      if (tid_rx != tid_count) return ST_BAD_TRANS;
      if ((frame[2] | frame[3]) != 8'h00) return ST_BAD_PROTO;
      if (frame[6] != unit_exp) return ST_BAD_UNIT;
      if (nbytes < HEADER_BYTES + 1 || frame[7][6:0] != func_exp) return ST_BAD_FUNC;
      return ST_VALID;
    endfunction

    // advance the state by one accepted item and queue its result
    function void take_item(op_e op, logic [7:0] unit, logic [6:0] func,
                            logic [7:0] rxb, logic [8:0] idx);
      result_t     r;
      status_e     st;
      logic        exc;
      logic [7:0]  dat;
      logic [15:0] plen;
      st  = ST_IGNORED;
      exc = 1'b0;
      dat = 8'h00;
      case (op)
        OP_START: begin
          if (ph == PH_IDLE) begin
            tid_count = tid_count + 1'b1;
            unit_exp  = unit;
            func_exp  = func;
            ticks     = 0;
            nbytes    = 0;
            ph        = PH_WAIT;
            st        = ST_ACCEPTED;
          end else begin
            st = ST_BUSY;
          end
        end
        OP_BYTE: begin
          if (ph != PH_IDLE) begin
            if (ph == PH_WAIT) begin
              ph     = PH_RECV;
              nbytes = 0;
            end
            if (nbytes >= BUFFER_BYTES) begin
              ph = PH_IDLE;
              st = ST_OVERFLOW;
            end else begin
              frame[nbytes] = rxb;
              nbytes++;
              st = ST_STORED;
              if (nbytes >= HEADER_BYTES) begin
                plen = {frame[4], frame[5]};
                if (plen == nbytes - MBAP_PRE) begin
                  st = judge_frame(exc);
                  ph = PH_IDLE;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (ph != PH_IDLE) begin
            if (ticks < TICK_MAX) ticks++;
            if (ticks > timeout_ticks) begin
              ph = PH_IDLE;
              st = ST_TIMEOUT;
            end
          end
        end
        default: begin
          st = ST_READ;
          if (idx < nbytes && idx < BUFFER_BYTES) dat = frame[idx];
        end
      endcase
      r.status             = st;
      r.phase_now          = ph;
      r.transaction_number = tid_count;
      r.data_byte          = dat;
      r.frame_length       = nbytes[FLEN_W-1:0];
      r.exception_flag     = exc;
      status_seen[st]++;
      awaited_results.push_back(r);
    endfunction

    function void check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: %s expected %0d got %0d", $time, field, exp_v, got_v);
      end
    endfunction

    // compare one output beat with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none got status %0d",
                   $time, got.status);
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      check_field("status", want.status, got.status);
      check_field("phase_now", want.phase_now, got.phase_now);
      check_field("transaction_number", want.transaction_number, got.transaction_number);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("exception_flag", want.exception_flag, got.exception_flag);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  modbus_rx_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int unsigned settings_used = 0;
  int          burst_left    = 0;
  bit          steady_sender = 1'b0;
  int          hold_request  = 0;

  modbus_tcp_response_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // offer one item, with random gaps between bursts
  task automatic send_item(input op_e op, input logic [7:0] unit, input logic [6:0] func,
                           input logic [7:0] rxb, input logic [8:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, rxb, func, unit};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.take_item(op, unit, func, rxb, idx);
    items_sent++;
  endtask

  // read positions mostly near the stored length, sometimes anywhere
  function automatic logic [8:0] pick_index();
    int top;
    if ($urandom_range(0, 3) == 0) return 9'($urandom_range(0, BUFFER_BYTES - 1));
    top = sb.nbytes + 1;
    if (top > BUFFER_BYTES - 1) top = BUFFER_BYTES - 1;
    return 9'($urandom_range(0, top));
  endfunction

  task automatic send_start(input logic [7:0] unit, input logic [6:0] func);
    send_item(OP_START, unit, func, 8'($urandom), pick_index());
  endtask

  task automatic send_byte(input logic [7:0] rxb);
    send_item(OP_BYTE, 8'($urandom), 7'($urandom), rxb, pick_index());
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom), 7'($urandom), 8'($urandom), pick_index());
  endtask

  task automatic send_read(input logic [8:0] idx);
    send_item(OP_READ, 8'($urandom), 7'($urandom), 8'($urandom), idx);
  endtask

  // timeout register write, only with nothing in flight
  task automatic write_timeout(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.timeout_ticks = value;
    settings_used++;
  endtask

  function automatic int pick_body();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(30, BUFFER_BYTES - HEADER_BYTES - 1);
    if (r < 5) return $urandom_range(9, 29);
    return $urandom_range(0, 8);
  endfunction

  function automatic resp_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return RK_VALID;
    if (r < 50) return RK_BAD_TID;
    if (r < 60) return RK_BAD_PROTO;
    if (r < 70) return RK_BAD_UNIT;
    if (r < 80) return RK_BAD_FUNC;
    if (r < 88) return RK_SHORT;
    if (r < 98) return RK_TIMEOUT;
    return RK_OVERFLOW;
  endfunction

  // one request and its response, with optional noise between the bytes
  task automatic run_exchange(input resp_kind_e kind);
    logic [7:0]  unit;
    logic [7:0]  ub;
    logic [7:0]  fbyte;
    logic [6:0]  func;
    logic [15:0] tid;
    logic [15:0] proto;
    logic [15:0] len;
    logic [7:0]  frame_q[$];
    int          body;
    int          nsend;
    bit          mix;
    unit = 8'($urandom);
    func = 7'($urandom);
    mix  = (kind != RK_OVERFLOW) && ($urandom_range(0, 2) != 0);
    send_start(unit, func);
    if ($urandom_range(0, 5) == 0) send_start(8'($urandom), 7'($urandom));
    if (kind == RK_TIMEOUT) begin
      // short timeouts are run out, long ones just see a few ticks
      if (sb.timeout_ticks <= 64) begin
        while (sb.ph != PH_IDLE) begin
          if ($urandom_range(0, 7) == 0) send_read(pick_index());
          else send_tick();
        end
        return;
      end
      repeat (3) send_tick();
    end
    tid   = sb.tid_count;
    proto = 16'h0000;
    ub    = unit;
    fbyte = {1'($urandom), func};
    body  = pick_body();
    len   = 16'(body + 2);
    case (kind)
      RK_BAD_TID:   tid = tid ^ 16'($urandom_range(1, 65535));
      RK_BAD_PROTO: begin
        case ($urandom_range(0, 2))
          0:       proto = {8'($urandom_range(1, 255)), 8'h00};
          1:       proto = {8'h00, 8'($urandom_range(1, 255))};
          default: proto = 16'($urandom_range(1, 65535));
        endcase
      end
      RK_BAD_UNIT:  ub = unit ^ 8'($urandom_range(1, 255));
      RK_BAD_FUNC:  fbyte[6:0] = func ^ 7'($urandom_range(1, 127));
      RK_SHORT:     len = 16'd1;
      RK_OVERFLOW: begin
        // a length the buffer can never hold, or zero
        if ($urandom_range(0, 3) == 0) len = 16'd0;
        else len = 16'($urandom_range(BUFFER_BYTES - MBAP_PRE + 1, 65535));
      end
      default: ;
    endcase
    frame_q = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0], ub};
    if (kind != RK_SHORT) frame_q.push_back(fbyte);
    if (kind == RK_OVERFLOW) nsend = BUFFER_BYTES + 1;
    else if (kind == RK_SHORT) nsend = HEADER_BYTES;
    else nsend = HEADER_BYTES + 1 + body;
    while (frame_q.size() < nsend) frame_q.push_back(8'($urandom));
    foreach (frame_q[i]) begin
      if (mix && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_tick();
          1: send_read(pick_index());
          default: if (sb.ph != PH_IDLE) send_start(8'($urandom), 7'($urandom));
        endcase
      end
      send_byte(frame_q[i]);
    end
    repeat ($urandom_range(0, 3)) send_read(pick_index());
  endtask

  // output side: stall pattern, one long hold-off on request, result check
  initial begin : receiver
    int         stall_left;
    int         mode_left;
    int         mode;
    logic [7:0] mask;
    result_t    got;
    stall_left = 0;
    mode_left  = 0;
    mode       = 0;
    mask       = 8'hA5;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got.status             = status_e'(m_axis_tuser);
        got.phase_now          = phase_e'(m_axis_tdata[1:0]);
        got.transaction_number = m_axis_tdata[17:2];
        got.data_byte          = m_axis_tdata[25:18];
        got.frame_length       = m_axis_tdata[34:26];
        got.exception_flag     = m_axis_tdata[35];
        sb.check_result(got);
      end
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
        mask      = 8'($urandom);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            m_axis_tready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [7:0]  hdr[$];
    logic [15:0] settings[5];
    int unsigned phase_start;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_START;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle behavior: empty read, tick and byte with no exchange
    send_read(9'd0);
    send_tick();
    send_byte(8'hFF);
    // start at field extremes, busy start, tick below the timeout
    send_start(8'hFF, 7'h7F);
    send_start(8'h00, 7'h00);
    send_tick();
    // good response with the exception bit set
    hdr = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF};
    foreach (hdr[i]) send_byte(hdr[i]);
    send_read(9'd7);
    send_read(9'd8);
    send_read(9'd259);
    // header only, no function byte
    send_start(8'h00, 7'h00);
    hdr = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
    foreach (hdr[i]) send_byte(hdr[i]);
    send_read(9'd256);

    // random exchanges under several timeout settings
    settings = '{16'd1, 16'($urandom_range(2, 64)), 16'd1000, 16'hFFFF,
                 16'($urandom_range(1, 65535))};
    foreach (settings[p]) begin
      write_timeout(settings[p]);
      steady_sender = (p == 2);
      if (p == 2) hold_request = HOLD_CYCLES;
      if (p == 0)
        for (int k = 0; k < RK_COUNT; k++) run_exchange(resp_kind_e'(k));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_exchange(pick_kind());
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d items, %0d results checked, %0d timeout settings, %0d mismatches",
             items_sent, sb.results_checked, settings_used, sb.errors);
    $display("good frames %0d, header errors %0d, overflows %0d, timeouts %0d, busy starts %0d",
             sb.status_seen[ST_VALID],
             sb.status_seen[ST_BAD_TRANS] + sb.status_seen[ST_BAD_PROTO] +
             sb.status_seen[ST_BAD_UNIT] + sb.status_seen[ST_BAD_FUNC],
             sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_TIMEOUT],
             sb.status_seen[ST_BUSY]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
